### src/rcpi_pkg.sv
// Shared constants and types for the ray / convex polyhedron clipper.
package rcpi_pkg;

	localparam int VALUE_WIDTH_DEF = 32;
	localparam int FRAC_BITS_DEF   = 16;
	localparam int MAX_PLANES_DEF  = 16;

	localparam int OP_W     = 2;
	localparam int FACE_W   = 4;
	localparam int STATUS_W = 2;

	typedef enum logic [OP_W-1:0] {
		OP_ORIGIN = 2'd0,
		OP_DIR    = 2'd1,
		OP_PLANE  = 2'd2,
		OP_FINAL  = 2'd3
	} opcode_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_MISS  = 2'd0,
		ST_FRONT = 2'd1,
		ST_BACK  = 2'd2
	} status_t;

	typedef enum logic [4:0] {
		S_IDLE = 5'b00001,
		S_DOT  = 5'b00010,
		S_DIV  = 5'b00100,
		S_UPD  = 5'b01000,
		S_FIN  = 5'b10000
	} state_t;

endpackage

### src/rcpi_dot.sv
// Bit-serial dot products vd = dir.n and vn = org.n + w, MSB-first Horner form.
module rcpi_dot import rcpi_pkg::*; #(
	parameter int VALUE_WIDTH = VALUE_WIDTH_DEF,
	parameter int FRAC_BITS   = FRAC_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  logic signed [VALUE_WIDTH-1:0]     dir [3],
	input  logic signed [VALUE_WIDTH-1:0]     org [3],
	input  logic signed [VALUE_WIDTH-1:0]     nrm [3],
	input  logic signed [VALUE_WIDTH-1:0]     ofs,
	output logic signed [2*VALUE_WIDTH+1:0]   vd,
	output logic signed [2*VALUE_WIDTH+1:0]   vn,
	output logic                              done
);
	localparam int W  = VALUE_WIDTH;
	localparam int AW = 2*VALUE_WIDTH+2;
	localparam int CW = $clog2(W+1);

	logic [W-1:0]           nsh_q [3];
	logic signed [W-1:0]    ofs_q;
	logic signed [AW-1:0]   acc_d_q, acc_n_q;
	logic [CW-1:0]          cnt_q;
	logic                   busy_q, done_q;
	logic signed [AW-1:0]   term_d, term_n;
	logic                   first;

	// sum of partial products selected by the current normal bits
	always_comb begin
		term_d = '0;
		term_n = '0;
		for (int k = 0; k < 3; k++) begin
			if (nsh_q[k][W-1]) begin
				term_d = term_d + AW'(dir[k]);
				term_n = term_n + AW'(org[k]);
			end
		end
		first = (cnt_q == '0);
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				if (cnt_q == CW'(W)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q + 1'b1;
				end
			end
		end
	end

	// datapath: sign bit weighs negative, then the offset term at the end
	always_ff @(posedge clk) begin
		if (start) begin
			for (int k = 0; k < 3; k++) nsh_q[k] <= nrm[k];
			ofs_q   <= ofs;
			acc_d_q <= '0;
			acc_n_q <= '0;
		end else if (busy_q) begin
			if (cnt_q == CW'(W)) begin
				acc_n_q <= acc_n_q + (AW'(ofs_q) <<< FRAC_BITS);
			end else begin
				for (int k = 0; k < 3; k++) nsh_q[k] <= {nsh_q[k][W-2:0], 1'b0};
				acc_d_q <= (acc_d_q <<< 1) + (first ? -term_d : term_d);
				acc_n_q <= (acc_n_q <<< 1) + (first ? -term_n : term_n);
			end
		end
	end

	assign vd   = acc_d_q;
	assign vn   = acc_n_q;
	assign done = done_q;

endmodule

### src/rcpi_div.sv
// Restoring divider, one quotient bit per cycle, saturating signed result.
module rcpi_div import rcpi_pkg::*; #(
	parameter int VALUE_WIDTH = VALUE_WIDTH_DEF,
	parameter int FRAC_BITS   = FRAC_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	input  logic [2*VALUE_WIDTH+1:0]        num_mag,
	input  logic [2*VALUE_WIDTH+1:0]        den_mag,
	input  logic                            neg,
	output logic signed [VALUE_WIDTH-1:0]   quo,
	output logic                            done
);
	localparam int W  = VALUE_WIDTH;
	localparam int AW = 2*VALUE_WIDTH+2;
	localparam int NB = AW + FRAC_BITS;
	localparam int CW = $clog2(NB+1);

	logic [NB-1:0]  num_q;
	logic [AW-1:0]  den_q;
	logic [AW:0]    rem_q;
	logic [W-1:0]   q_q;
	logic           ovf_q, neg_q;
	logic [CW-1:0]  cnt_q;
	logic           busy_q, done_q;
	logic [AW:0]    rem_sh, rem_sub;
	logic           qbit;

	// one trial subtract
	always_comb begin
		rem_sh  = {rem_q[AW-1:0], num_q[NB-1]};
		rem_sub = rem_sh - {1'b0, den_q};
		qbit    = (rem_sh >= {1'b0, den_q});
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CW'(NB-1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// datapath; quotient bits above the result width fold into an overflow flag
	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= {num_mag, {FRAC_BITS{1'b0}}};
			den_q <= den_mag;
			neg_q <= neg;
			rem_q <= '0;
			q_q   <= '0;
			ovf_q <= 1'b0;
		end else if (busy_q) begin
			num_q <= {num_q[NB-2:0], 1'b0};
			rem_q <= qbit ? rem_sub : rem_sh;
			ovf_q <= ovf_q | q_q[W-1];
			q_q   <= {q_q[W-2:0], qbit};
		end
	end

	// saturate to the signed range
	always_comb begin
		if (ovf_q || q_q[W-1])
			quo = neg_q ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
		else
			quo = neg_q ? -$signed(q_q) : $signed(q_q);
	end

	assign done = done_q;

endmodule

### src/ray_convex_polyhedron_intersect.sv
// Top level: ray clipping against a stream of bounding planes.
//
//  channel | handshake          | beat
//  in      | in_valid/in_stall  | opcode, val_a..val_d, plane_number
//  out     | out_valid/out_stall| hit_status, hit_distance, face_number
//
// Load beats are taken directly in the idle state. A plane passes through the
// bit-serial dot unit, the serial divider, then the update and finish states;
// a parallel plane skips the divider and the update, and a skipped plane goes
// straight to the finish state.
// Reset clears all ray state. A final result waits in the output register;
// only a second final plane stalls behind it.
module ray_convex_polyhedron_intersect import rcpi_pkg::*; #(
	parameter int VALUE_WIDTH = VALUE_WIDTH_DEF,
	parameter int FRAC_BITS   = FRAC_BITS_DEF,
	parameter int MAX_PLANES  = MAX_PLANES_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [OP_W-1:0]               opcode,
	input  logic signed [VALUE_WIDTH-1:0] val_a,
	input  logic signed [VALUE_WIDTH-1:0] val_b,
	input  logic signed [VALUE_WIDTH-1:0] val_c,
	input  logic signed [VALUE_WIDTH-1:0] val_d,
	input  logic [FACE_W-1:0]             plane_number,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [STATUS_W-1:0]           hit_status,
	output logic signed [VALUE_WIDTH-1:0] hit_distance,
	output logic [FACE_W-1:0]             face_number
);
	localparam int W  = VALUE_WIDTH;
	localparam int AW = 2*VALUE_WIDTH+2;
	localparam int PW = $clog2(MAX_PLANES+1);
	localparam logic signed [W-1:0] VMIN = {1'b1, {(W-1){1'b0}}};

	state_t                state_q;
	opcode_t               op_q;
	logic [FACE_W-1:0]     face_q;
	logic signed [W-1:0]   org_q [3];
	logic signed [W-1:0]   dir_q [3];
	logic signed [W-1:0]   nrm [3];
	logic signed [W-1:0]   maxd_q, near_q, far_q;
	logic [FACE_W-1:0]     near_face_q, far_face_q;
	logic                  missed_q;
	logic [PW-1:0]         count_q;
	logic                  out_valid_q;
	logic [STATUS_W-1:0]   status_q;
	logic signed [W-1:0]   dist_q;
	logic [FACE_W-1:0]     oface_q;

	logic                  accept, dot_start, dot_done, div_start, div_done;
	logic                  out_load;
	logic signed [AW-1:0]  vd, vn;
	logic [AW-1:0]         vd_mag, vn_mag;
	logic                  t_neg;
	logic signed [W-1:0]   t;
	status_t               res_status;
	logic signed [W-1:0]   res_dist;
	logic [FACE_W-1:0]     res_face;

	assign in_stall = (state_q != S_IDLE);
	assign accept   = in_valid && !in_stall;
	assign nrm[0]   = val_a;
	assign nrm[1]   = val_b;
	assign nrm[2]   = val_c;

	assign dot_start = accept && (opcode == OP_PLANE || opcode == OP_FINAL) &&
		!missed_q && (count_q < PW'(MAX_PLANES));

	// final result moves into the output register
	assign out_load = (state_q == S_FIN) && (op_q == OP_FINAL) &&
		(!out_valid_q || !out_stall);

	rcpi_dot #(.VALUE_WIDTH(VALUE_WIDTH), .FRAC_BITS(FRAC_BITS)) u_dot (
		.clk(clk), .arst_n(arst_n), .start(dot_start),
		.dir(dir_q), .org(org_q), .nrm(nrm), .ofs(val_d),
		.vd(vd), .vn(vn), .done(dot_done)
	);

	// magnitudes and quotient sign
	assign vd_mag = vd[AW-1] ? AW'(-vd) : AW'(vd);
	assign vn_mag = vn[AW-1] ? AW'(-vn) : AW'(vn);
	assign t_neg  = (vn[AW-1] == vd[AW-1]) && (vn != '0);
	assign div_start = (state_q == S_DOT) && dot_done && (vd != '0);

	rcpi_div #(.VALUE_WIDTH(VALUE_WIDTH), .FRAC_BITS(FRAC_BITS)) u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start),
		.num_mag(vn_mag), .den_mag(vd_mag), .neg(t_neg),
		.quo(t), .done(div_done)
	);

	// result selection for the final plane
	always_comb begin
		res_status = ST_MISS;
		res_dist   = '0;
		res_face   = '0;
		if (!missed_q) begin
			priority if (!near_q[W-1]) begin
				res_status = ST_FRONT;
				res_dist   = near_q;
				res_face   = near_face_q;
			end else if (far_q < maxd_q) begin
				res_status = ST_BACK;
				res_dist   = far_q;
				res_face   = far_face_q;
			end else begin
				res_status = ST_MISS;
			end
		end
	end

	// sequencer and ray state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			op_q        <= OP_ORIGIN;
			face_q      <= '0;
			for (int k = 0; k < 3; k++) begin
				org_q[k] <= '0;
				dir_q[k] <= '0;
			end
			maxd_q      <= '0;
			near_q      <= VMIN;
			far_q       <= '0;
			near_face_q <= '0;
			far_face_q  <= '0;
			missed_q    <= 1'b0;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_load)
				out_valid_q <= 1'b1;
			else if (out_valid_q && !out_stall)
				out_valid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						op_q   <= opcode_t'(opcode);
						face_q <= plane_number;
						unique case (opcode_t'(opcode))
							OP_ORIGIN: begin
								org_q[0]    <= val_a;
								org_q[1]    <= val_b;
								org_q[2]    <= val_c;
								maxd_q      <= val_d;
								near_q      <= VMIN;
								far_q       <= val_d;
								near_face_q <= '0;
								far_face_q  <= '0;
								missed_q    <= 1'b0;
								count_q     <= '0;
							end
							OP_DIR: begin
								dir_q[0] <= val_a;
								dir_q[1] <= val_b;
								dir_q[2] <= val_c;
							end
							OP_PLANE, OP_FINAL: begin
								if (dot_start) begin
									count_q <= count_q + 1'b1;
									state_q <= S_DOT;
								end else begin
									state_q <= S_FIN;
								end
							end
							default: ;
						endcase
					end
				end
				S_DOT: begin
					if (dot_done) begin
						if (vd == '0) begin
							// parallel plane, origin outside
							if (!vn[AW-1] && vn != '0)
								missed_q <= 1'b1;
							state_q <= S_FIN;
						end else begin
							state_q <= S_DIV;
						end
					end
				end
				S_DIV: begin
					if (div_done)
						state_q <= S_UPD;
				end
				S_UPD: begin
					if (vd[AW-1]) begin
						if (t > far_q)
							missed_q <= 1'b1;
						else if (t > near_q) begin
							near_q      <= t;
							near_face_q <= face_q;
						end
					end else begin
						if (t < near_q)
							missed_q <= 1'b1;
						else if (t < far_q) begin
							far_q      <= t;
							far_face_q <= face_q;
						end
					end
					state_q <= S_FIN;
				end
				S_FIN: begin
					if (op_q != OP_FINAL) begin
						state_q <= S_IDLE;
					end else if (!out_valid_q || !out_stall) begin
						near_q      <= VMIN;
						far_q       <= maxd_q;
						near_face_q <= '0;
						far_face_q  <= '0;
						missed_q    <= 1'b0;
						count_q     <= '0;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// output beat register
	always_ff @(posedge clk) begin
		if (out_load) begin
			status_q <= res_status;
			dist_q   <= res_dist;
			oface_q  <= res_face;
		end
	end

	assign out_valid    = out_valid_q;
	assign hit_status   = status_q;
	assign hit_distance = dist_q;
	assign face_number  = oface_q;

endmodule

### tb/ray_convex_polyhedron_intersect_tb.sv
// Self-checking testbench for the ray / convex polyhedron clipper.
module ray_convex_polyhedron_intersect_tb;
	import rcpi_pkg::*;

	localparam int VW        = VALUE_WIDTH_DEF;
	localparam int FB        = FRAC_BITS_DEF;
	localparam int NPL       = MAX_PLANES_DEF;
	localparam int ONE       = 1 << FB;
	localparam int IDLE_LIMIT = 6000;
	localparam int TAIL_CYCLES = 300;
	localparam logic signed [VW-1:0] VAL_MAX = {1'b0, {(VW-1){1'b1}}};
	localparam logic signed [VW-1:0] VAL_MIN = {1'b1, {(VW-1){1'b0}}};

	typedef struct {
		opcode_t                op;
		logic signed [VW-1:0]   a, b, c, d;
		logic [FACE_W-1:0]      pn;
	} beat_t;

	typedef struct {
		status_t                st;
		logic signed [VW-1:0]   distance;
		logic [FACE_W-1:0]      face;
	} hit_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [OP_W-1:0] opcode = '0;
	logic signed [VW-1:0] val_a = '0, val_b = '0, val_c = '0, val_d = '0;
	logic [FACE_W-1:0] plane_number = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [STATUS_W-1:0] hit_status;
	logic signed [VW-1:0] hit_distance;
	logic [FACE_W-1:0] face_number;

	ray_convex_polyhedron_intersect dut (.*);

	always #10 clk = ~clk;

	beat_t pending_beats[$];
	hit_t  expected_hits[$];
	int    errors = 0;
	int    beats_taken = 0;
	int    status_seen[3] = '{0, 0, 0};
	int    idle_cycles = 0;

	// predictor copy of the ray state
	logic signed [VW-1:0] p_org[3], p_dir[3];
	logic signed [VW-1:0] p_maxd, p_near, p_far;
	logic [FACE_W-1:0]    p_nface, p_fface;
	logic                 p_missed;
	int                   p_count;

	function automatic void rearm_ray();
		p_near = VAL_MIN;
		p_far = p_maxd;
		p_nface = '0;
		p_fface = '0;
		p_missed = 1'b0;
		p_count = 0;
	endfunction

	// t = -vn/vd, truncated toward zero, saturated
	function automatic logic signed [VW-1:0] plane_distance(logic signed [127:0] vn,
			logic signed [127:0] vd);
		logic neg;
		logic [127:0] num, den, q;
		neg = (vn[127] == vd[127]) && (vn != 0);
		num = (vn[127] ? -vn : vn) << FB;
		den = vd[127] ? -vd : vd;
		q = num / den;
		if (neg) begin
			if (q >= (128'd1 << (VW-1))) return VAL_MIN;
			return -$signed(q[VW-1:0]);
		end
		if (q > (128'd1 << (VW-1)) - 1) return VAL_MAX;
		return $signed(q[VW-1:0]);
	endfunction

	function automatic void clip_against(beat_t bt);
		logic signed [127:0] vd, vn, n0, n1, n2, wd;
		logic signed [127:0] o0, o1, o2, d0, d1, d2;
		logic signed [VW-1:0] t;
		if (p_missed || p_count >= NPL) return;
		p_count++;
		n0 = bt.a; n1 = bt.b; n2 = bt.c; wd = bt.d;
		o0 = p_org[0]; o1 = p_org[1]; o2 = p_org[2];
		d0 = p_dir[0]; d1 = p_dir[1]; d2 = p_dir[2];
		vd = d0 * n0 + d1 * n1 + d2 * n2;
		vn = o0 * n0 + o1 * n1 + o2 * n2 + (wd <<< FB);
		if (vd == 0) begin
			if (vn > 0) p_missed = 1'b1;
			return;
		end
		t = plane_distance(vn, vd);
		if (vd < 0) begin
			if (t > p_far) p_missed = 1'b1;
			else if (t > p_near) begin
				p_near = t;
				p_nface = bt.pn;
			end
		end else begin
			if (t < p_near) p_missed = 1'b1;
			else if (t < p_far) begin
				p_far = t;
				p_fface = bt.pn;
			end
		end
	endfunction

	function automatic void predict_beat(beat_t bt);
		hit_t h;
		case (bt.op)
			OP_ORIGIN: begin
				p_org = '{bt.a, bt.b, bt.c};
				p_maxd = bt.d;
				rearm_ray();
			end
			OP_DIR: p_dir = '{bt.a, bt.b, bt.c};
			default: begin
				clip_against(bt);
				if (bt.op == OP_FINAL) begin
					h = '{ST_MISS, '0, '0};
					if (!p_missed) begin
						if (p_near >= 0) h = '{ST_FRONT, p_near, p_nface};
						else if (p_far < p_maxd) h = '{ST_BACK, p_far, p_fface};
					end
					expected_hits.push_back(h);
					rearm_ray();
				end
			end
		endcase
	endfunction

	// monitor: inputs feed the predictor, outputs checked against the oldest hit
	logic in_took = 1'b0;
	always @(posedge clk) begin
		hit_t e;
		beat_t bt;
		if (arst_n) begin
			in_took <= in_valid && !in_stall;
			if (in_valid && !in_stall) begin
				bt = '{opcode_t'(opcode), val_a, val_b, val_c, val_d, plane_number};
				predict_beat(bt);
				beats_taken++;
			end
			if (out_valid && !out_stall) begin
				if (expected_hits.size() == 0) begin
					$error("unexpected result beat: status %0d dist %0d face %0d",
						hit_status, hit_distance, face_number);
					errors++;
				end else begin
					e = expected_hits.pop_front();
					if (hit_status < 3) status_seen[hit_status]++;
					if (hit_status !== e.st) begin
						$error("hit_status: expected %0d, got %0d", e.st, hit_status);
						errors++;
					end
					if (hit_distance !== e.distance) begin
						$error("hit_distance: expected %0d, got %0d", e.distance,
							hit_distance);
						errors++;
					end
					if (face_number !== e.face) begin
						$error("face_number: expected %0d, got %0d", e.face, face_number);
						errors++;
					end
				end
			end
			// watchdog on stalled progress
			if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
			else if (idle_cycles >= IDLE_LIMIT) begin
				$display("tb: failure");
				$finish;
			end else idle_cycles <= idle_cycles + 1;
		end
	end

	// driver: bursts of beats separated by random gaps
	int burst_left = 4, gap_left = 0;
	always @(negedge clk) begin
		beat_t bt;
		if (arst_n && !(in_valid && !in_took)) begin
			if (gap_left > 0) begin
				in_valid <= 1'b0;
				gap_left--;
			end else if (pending_beats.size() > 0) begin
				bt = pending_beats.pop_front();
				in_valid <= 1'b1;
				opcode <= bt.op;
				val_a <= bt.a;
				val_b <= bt.b;
				val_c <= bt.c;
				val_d <= bt.d;
				plane_number <= bt.pn;
				burst_left--;
				if (burst_left <= 0) begin
					burst_left = $urandom_range(1, 30);
					gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 25);
				end
			end else in_valid <= 1'b0;
		end
	end

	// receiver stall pattern: phases of none, light and heavy stalling
	int stall_mode = 0, stall_phase = 0;
	always @(negedge clk) begin
		if (stall_phase == 0) begin
			stall_mode = $urandom_range(0, 2);
			stall_phase = $urandom_range(50, 2000);
		end
		stall_phase--;
		case (stall_mode)
			0: out_stall <= 1'b0;
			1: out_stall <= ($urandom_range(0, 3) == 0);
			default: out_stall <= ($urandom_range(0, 9) < 8);
		endcase
	end

	function automatic logic signed [VW-1:0] some_value();
		case ($urandom_range(0, 9))
			0: return $urandom;
			1: case ($urandom_range(0, 4))
				0: return VAL_MAX;
				1: return VAL_MIN;
				2: return 0;
				3: return -1;
				default: return 1;
			endcase
			default: return $signed($urandom_range(0, 16 * ONE)) - 8 * ONE;
		endcase
	endfunction

	function automatic void add_beat(opcode_t op, logic signed [VW-1:0] a, b, c, d,
			logic [FACE_W-1:0] pn);
		pending_beats.push_back('{op, a, b, c, d, pn});
	endfunction

	// well-formed ray against an axis box, with some noise planes mixed in
	function automatic void add_box_ray();
		int half, np, k, axis, sgn;
		logic signed [VW-1:0] n[3];
		half = $urandom_range(1, 6) * ONE + $urandom_range(0, ONE - 1);
		add_beat(OP_ORIGIN, some_value(), some_value(), some_value(),
			($urandom_range(0, 5) == 0) ? some_value() : $urandom_range(0, 64 * ONE),
			FACE_W'($urandom));
		if ($urandom_range(0, 5) != 0)
			add_beat(OP_DIR, some_value(), some_value(), some_value(), $urandom,
				FACE_W'($urandom));
		np = ($urandom_range(0, 19) == 0) ? $urandom_range(0, 20) : $urandom_range(0, 7);
		for (k = 0; k < np; k++) begin
			if ($urandom_range(0, 3) == 0) begin
				add_beat(OP_PLANE, some_value(), some_value(), some_value(), some_value(),
					FACE_W'($urandom));
			end else begin
				axis = $urandom_range(0, 2);
				sgn = $urandom_range(0, 1) ? ONE : -ONE;
				n = '{0, 0, 0};
				n[axis] = sgn;
				add_beat(OP_PLANE, n[0], n[1], n[2], -half, FACE_W'($urandom));
			end
		end
		add_beat(OP_FINAL, some_value(), some_value(), some_value(), some_value(),
			FACE_W'($urandom));
	endfunction

	initial begin
		int rays;
		// directed: through a unit box along +x, entering front face
		add_beat(OP_ORIGIN, -4 * ONE, 0, 0, 100 * ONE, 4'd0);
		add_beat(OP_DIR, ONE, 0, 0, 0, 4'd0);
		add_beat(OP_PLANE, ONE, 0, 0, -ONE, 4'd3);
		add_beat(OP_PLANE, 0, ONE, 0, -ONE, 4'd5);
		add_beat(OP_FINAL, -ONE, 0, 0, -ONE, 4'd15);
		// origin inside, leaving through a back face
		add_beat(OP_ORIGIN, 0, 0, 0, 100 * ONE, 4'd0);
		add_beat(OP_FINAL, ONE, 0, 0, -2 * ONE, 4'd9);
		// parallel plane with origin outside, then planes after the miss
		add_beat(OP_PLANE, 0, ONE, 0, ONE, 4'd1);
		add_beat(OP_PLANE, ONE, 0, 0, -ONE, 4'd2);
		add_beat(OP_FINAL, -ONE, 0, 0, -ONE, 4'd4);
		// more planes than the block clips against
		for (int k = 0; k < NPL + 2; k++)
			add_beat(OP_PLANE, ONE, 0, 0, -(k + 1) * ONE, 4'(k));
		add_beat(OP_FINAL, ONE, 0, 0, -ONE, 4'd12);
		// saturation: tiny direction, huge offset; negative max distance
		add_beat(OP_DIR, 1, 0, 0, 0, 4'd0);
		add_beat(OP_FINAL, VAL_MIN, 0, 0, VAL_MAX, 4'd7);
		add_beat(OP_ORIGIN, VAL_MAX, VAL_MIN, VAL_MAX, -5 * ONE, 4'hF);
		add_beat(OP_DIR, VAL_MIN, VAL_MAX, VAL_MIN, VAL_MIN, 4'hF);
		add_beat(OP_PLANE, VAL_MAX, VAL_MAX, VAL_MIN, VAL_MIN, 4'hA);
		add_beat(OP_FINAL, VAL_MIN, VAL_MIN, VAL_MAX, VAL_MAX, 4'h5);

		// random rays until about 1500 beats are queued
		rays = 0;
		while (pending_beats.size() < 1500) begin
			add_box_ray();
			rays++;
		end

		repeat (8) @(posedge clk);
		@(negedge clk) arst_n <= 1'b1;

		do @(posedge clk);
		while (pending_beats.size() != 0 || in_valid || expected_hits.size() != 0);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (expected_hits.size() != 0) begin
			$error("%0d expected results never arrived", expected_hits.size());
			errors++;
		end

		$display("covered %0d beats over %0d random rays plus directed cases", beats_taken,
			rays);
		$display("results: %0d missed, %0d front face, %0d back face", status_seen[0],
			status_seen[1], status_seen[2]);
		if (errors == 0) $display("tb: success");
		else $display("tb: failure");
		$finish;
	end

endmodule
